[src/htpr_pkg.sv]
`timescale 1ns / 1ps

package htpr_pkg;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int TAG_LSB = 48;
  localparam int TAG_W = 16;
  localparam int AGE_BIAS = 259;
  localparam logic [7:0] AGE_MASK = 8'hfc;
  localparam logic [7:0] BOUND_MASK = 8'h03;

  typedef struct packed {
    logic [1:0]        operation;
    logic [63:0]       position_key;
    logic [1:0]        write_way;
    logic [15:0]       write_tag;
    logic signed [7:0] write_depth;
    logic [7:0]        write_gen_bound;
  } htpr_in_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        chosen_way;
    logic [15:0]       entry_tag;
    logic signed [7:0] entry_depth;
    logic [7:0]        entry_gen_bound;
  } htpr_out_t;

  typedef struct packed {
    logic [15:0]       tag;
    logic signed [7:0] depth;
    logic [7:0]        gen_bound;
  } htpr_entry_t;

endpackage

[src/htpr_ram.sv]
`timescale 1ns / 1ps

module htpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/hash_table_probe_replace.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  htpr_in_t  (operation, key, write fields)
// out       output     out_valid_o/out_stall_i htpr_out_t (found, way, entry fields)
// cfg       input      cfg_we_i               cfg_wdata_i (current generation)
//
// Probe, write and unused codes: the cluster row is read on accept and the modified
// row is written back in ST_RD once the output is free, one access per cycle to the RAM.
// Clear sweeps every cluster row, one per cycle.
// After reset the same sweep runs with in_stall_o high.
// A result waits in the output register; a stalled output holds the next item's
// write-back until the register frees.

module hash_table_probe_replace
  import htpr_pkg::*;
#(
  parameter int CLUSTER_INDEX_BITS = 16,
  parameter int WAYS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  htpr_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output htpr_out_t out_o,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CLUSTERS = 2 ** CLUSTER_INDEX_BITS;
  localparam int EW = $bits(htpr_entry_t);
  localparam int ROW_W = WAYS * EW;
  localparam int WAY_W = $clog2(WAYS);
  localparam int SCORE_W = 11;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CLR  = 2'd2;
  localparam logic [1:0] ST_INIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CLUSTER_INDEX_BITS-1:0] sweep_q, sweep_d;
  logic [7:0] gen_q;
  htpr_in_t item_q;
  logic out_valid_q, out_valid_d;
  htpr_out_t out_q;

  logic accept, sweeping, out_free, wb_en;
  logic ram_we;
  logic [CLUSTER_INDEX_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, rdata, new_row;
  htpr_out_t res;

  htpr_entry_t ways [WAYS];
  htpr_entry_t new_ways [WAYS];

  function automatic logic signed [SCORE_W-1:0] score(htpr_entry_t e, logic [7:0] gen);
    logic [7:0] age;
    age = (8'(AGE_BIAS) + gen - e.gen_bound) & AGE_MASK;
    return $signed({{3{e.depth[7]}}, e.depth}) - $signed({2'b00, age, 1'b0});
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign sweeping = (state_q == ST_CLR) || (state_q == ST_INIT);
  assign out_free = !out_valid_q || !out_stall_i;

  htpr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CLUSTERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(in_i.position_key[CLUSTER_INDEX_BITS-1:0]),
    .rdata_o(rdata)
  );

  assign ram_we = sweeping || ((state_q == ST_RD) && out_free && wb_en);
  assign ram_waddr = sweeping ? sweep_q : item_q.position_key[CLUSTER_INDEX_BITS-1:0];
  assign ram_wdata = sweeping ? '0 : new_row;

  // Probe compare, victim selection and row update on the returned cluster.
  always_comb begin
    logic [15:0] key16;
    logic hit_found;
    logic [WAY_W-1:0] hit_idx, vic_idx, pick;
    logic signed [SCORE_W-1:0] best, s;
    htpr_entry_t e;
    key16 = item_q.position_key[TAG_LSB+TAG_W-1:TAG_LSB];
    for (int i = 0; i < WAYS; i++) begin
      ways[i] = htpr_entry_t'(rdata[i*EW +: EW]);
      new_ways[i] = ways[i];
    end
    hit_found = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_found && (ways[i].tag == '0 || ways[i].tag == key16)) begin
        hit_found = 1'b1;
        hit_idx = WAY_W'(i);
      end
    end
    vic_idx = '0;
    best = score(ways[0], gen_q);
    for (int i = 1; i < WAYS; i++) begin
      s = score(ways[i], gen_q);
      if (best > s) begin
        best = s;
        vic_idx = WAY_W'(i);
      end
    end
    res = '0;
    wb_en = 1'b0;
    e = ways[vic_idx];
    pick = vic_idx;
    case (item_q.operation)
      OP_PROBE: begin
        if (hit_found) begin
          e = ways[hit_idx];
          pick = hit_idx;
          if (e.tag != '0 && (e.gen_bound & AGE_MASK) != gen_q) begin
            e.gen_bound = gen_q | (e.gen_bound & BOUND_MASK);
            new_ways[hit_idx] = e;
            wb_en = 1'b1;
          end
          res.found = (e.tag != '0);
        end
        res.chosen_way = 2'(pick);
        res.entry_tag = e.tag;
        res.entry_depth = e.depth;
        res.entry_gen_bound = e.gen_bound;
      end
      OP_WRITE: begin
        for (int i = 0; i < WAYS; i++) begin
          if (i == int'(item_q.write_way)) begin
            new_ways[i] = '{tag: item_q.write_tag, depth: item_q.write_depth,
                            gen_bound: item_q.write_gen_bound};
            wb_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < WAYS; i++) begin
      new_row[i*EW +: EW] = new_ways[i];
    end
  end

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.operation == OP_CLEAR) begin
            state_d = ST_CLR;
            sweep_d = '0;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CLR, ST_INIT: begin
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          // a clear still owes its result; the reset sweep does not
          state_d = (state_q == ST_CLR) ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      gen_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        gen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
    if (state_q == ST_RD && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

[src/htpr_chk.sv]
`timescale 1ns / 1ps

module htpr_chk
  import htpr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input htpr_out_t out_o
);

  logic in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an item");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q <= 2'd1)
    else $error("item taken while another is still in work");

  a_found_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.found |-> out_o.entry_tag != '0)
    else $error("hit reported on an empty entry");

endmodule

bind hash_table_probe_replace htpr_chk u_htpr_chk (.*);

[dv/tb_hash_table_probe_replace.sv]
`timescale 1ns / 1ps

module tb_hash_table_probe_replace;
  import htpr_pkg::*;

  localparam int CLUSTER_INDEX_BITS = 16;
  localparam int WAYS = 3;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_GAP = 18;
  localparam int SETTLE_CYCLES = 6;
  localparam int END_LIMIT = 200000;
  localparam int HOT_CLUSTERS = 6;
  localparam int HOT_TAGS = 5;
  localparam int REPORT_LIMIT = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  htpr_in_t   in_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  htpr_out_t  out_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  // Shadow copy of the entry store; a missing key is an empty entry.
  htpr_entry_t shadow_table [int unsigned];
  logic [7:0]  gen_model = '0;
  htpr_out_t   pending_results [$];

  logic [CLUSTER_INDEX_BITS-1:0] hot_clusters [HOT_CLUSTERS];
  logic [15:0]                   hot_tags [HOT_TAGS];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_holdoff_cycles = 0;

  int fail_count = 0;
  int results_checked = 0;
  int probe_count = 0;
  int hit_count = 0;
  int write_count = 0;
  int clear_count = 0;
  int unused_count = 0;
  int gen_settings = 0;

  hash_table_probe_replace #(
    .CLUSTER_INDEX_BITS(CLUSTER_INDEX_BITS),
    .WAYS(WAYS)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o(out_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic htpr_entry_t read_entry(input int unsigned addr);
    if (shadow_table.exists(addr)) return shadow_table[addr];
    return '0;
  endfunction

  // Replacement score: depth minus twice the age; lower is the better victim.
  function automatic int victim_score(input htpr_entry_t e);
    int age;
    age = (AGE_BIAS + int'(gen_model) - int'(e.gen_bound)) & int'(AGE_MASK);
    return int'($signed(e.depth)) - 2 * age;
  endfunction

  function automatic htpr_out_t model_table_access(input htpr_in_t it);
    htpr_out_t   res;
    htpr_entry_t e;
    int unsigned base;
    logic [15:0] probe_tag;
    int          pick;
    int          best;
    int          s;
    int          w;
    res = '0;
    base = int'(it.position_key[CLUSTER_INDEX_BITS-1:0]) * WAYS;
    case (it.operation)
      OP_CLEAR: begin
        shadow_table.delete();
      end
      OP_WRITE: begin
        if (int'(it.write_way) < WAYS) begin
          e.tag = it.write_tag;
          e.depth = it.write_depth;
          e.gen_bound = it.write_gen_bound;
          shadow_table[base + it.write_way] = e;
        end
      end
      OP_PROBE: begin
        probe_tag = it.position_key[TAG_LSB +: TAG_W];
        pick = -1;
        for (w = 0; w < WAYS; w++) begin
          e = read_entry(base + w);
          if (pick < 0 && (e.tag == '0 || e.tag == probe_tag)) pick = w;
        end
        if (pick >= 0) begin
          e = read_entry(base + pick);
          // Refresh a hit from another generation, keep its bound.
          if (e.tag != '0 && (e.gen_bound & AGE_MASK) != gen_model) begin
            e.gen_bound = gen_model | (e.gen_bound & BOUND_MASK);
            shadow_table[base + pick] = e;
          end
          res.found = (e.tag != '0);
        end else begin
          pick = 0;
          best = victim_score(read_entry(base));
          for (w = 1; w < WAYS; w++) begin
            s = victim_score(read_entry(base + w));
            if (s < best) begin
              best = s;
              pick = w;
            end
          end
          e = read_entry(base + pick);
        end
        res.chosen_way = pick[1:0];
        res.entry_tag = e.tag;
        res.entry_depth = e.depth;
        res.entry_gen_bound = e.gen_bound;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int draw_gap(input bit busy);
    if (!busy) return 0;
    if ($urandom_range(0, 1) != 0) return 0;
    return int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic htpr_in_t make_item(input logic [1:0] op, input logic [63:0] key,
                                         input logic [1:0] way, input logic [15:0] tag,
                                         input logic signed [7:0] depth,
                                         input logic [7:0] gen_bound);
    htpr_in_t it;
    it.operation = op;
    it.position_key = key;
    it.write_way = way;
    it.write_tag = tag;
    it.write_depth = depth;
    it.write_gen_bound = gen_bound;
    return it;
  endfunction

  function automatic logic [15:0] pick_tag();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r < 5) return 16'($urandom);
    return hot_tags[$urandom_range(0, HOT_TAGS - 1)];
  endfunction

  // Mostly probe/write traffic on a few hot clusters so ways fill, hit and age out.
  function automatic htpr_in_t random_item();
    htpr_in_t it;
    int       r;
    r = $urandom_range(0, 99);
    it.position_key = {pick_tag(), 32'($urandom),
                       hot_clusters[$urandom_range(0, HOT_CLUSTERS - 1)]};
    it.write_way = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, WAYS - 1));
    it.write_tag = ($urandom_range(0, 9) == 0) ? 16'h0000 : pick_tag();
    it.write_depth = 8'($urandom);
    if ($urandom_range(0, 3) == 0) it.write_gen_bound = 8'($urandom);
    else it.write_gen_bound = {gen_model[7:2] - 6'($urandom_range(0, 3)), 2'($urandom)};
    if (r < 50) begin
      it.operation = OP_PROBE;
    end else if (r < 92) begin
      it.operation = OP_WRITE;
    end else if (r < 95) begin
      it.operation = OP_UNUSED;
    end else begin
      // Noise: any key, any fields; clear is kept out since it sweeps the whole store.
      it.position_key = {$urandom, $urandom};
      it.write_tag = 16'($urandom);
      it.operation = ($urandom_range(0, 2) == 0) ? OP_WRITE :
                     ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_PROBE;
    end
    return it;
  endfunction

  task automatic send_item(input htpr_in_t item);
    int        gap;
    htpr_out_t res;
    gap = draw_gap(tx_idle_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    res = model_table_access(item);
    pending_results.push_back(res);
    case (item.operation)
      OP_PROBE: begin
        probe_count++;
        if (res.found) hit_count++;
      end
      OP_WRITE: write_count++;
      OP_CLEAR: clear_count++;
      default:  unused_count++;
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_generation(input logic [7:0] gen);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= gen;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_model = gen;
    gen_settings++;
  endtask

  task automatic check_result(input htpr_out_t got);
    htpr_out_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("unexpected result: found=%0d way=%0d tag=%h depth=%0d gb=%h",
                 got.found, got.chosen_way, got.entry_tag, got.entry_depth,
                 got.entry_gen_bound);
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found || got.chosen_way !== want.chosen_way ||
        got.entry_tag !== want.entry_tag || got.entry_depth !== want.entry_depth ||
        got.entry_gen_bound !== want.entry_gen_bound) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("mismatch at %0t: expected found=%0d way=%0d tag=%h depth=%0d gb=%h, got found=%0d way=%0d tag=%h depth=%0d gb=%h",
                 $realtime, want.found, want.chosen_way, want.entry_tag, want.entry_depth,
                 want.entry_gen_bound, got.found, got.chosen_way, got.entry_tag,
                 got.entry_depth, got.entry_gen_bound);
    end
  endtask

  initial begin
    int wait_n;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_holdoff_cycles > 0) begin
        wait_n = rx_holdoff_cycles;
        rx_holdoff_cycles = 0;
      end else begin
        wait_n = draw_gap(rx_idle_on);
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_result(out_o);
    end
  end

  task automatic test_empty_table();
    wait_drained();
    write_generation(8'd0);
    send_item(make_item(OP_PROBE, 64'hFFFF_0000_0000_0000, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_PROBE, 64'h0, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_UNUSED, '1, 2'd3, 16'hFFFF, -8'sd1, 8'hFF));
  endtask

  task automatic test_hit_refresh_replace();
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_FFFF, 2'd0, 16'h0001, -8'sd128, 8'hFF));
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_FFFF, 2'd1, 16'hFFFF, 8'sd127, 8'h00));
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_FFFF, 2'd2, 16'h8000, 8'sd0, 8'h7E));
    // Way 3 does not exist; drop the write.
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_FFFF, 2'd3, 16'h1234, 8'sd5, 8'h04));
    send_item(make_item(OP_PROBE, '1, 2'd0, 16'h0, 8'sd0, 8'h00));
    wait_drained();
    write_generation(8'd8);
    send_item(make_item(OP_PROBE, 64'h0001_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_PROBE, 64'h8000_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_PROBE, 64'h1234_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
    // Zero tag on a full cluster falls through to replacement.
    send_item(make_item(OP_PROBE, 64'h0000_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_WRITE, 64'h0000_0000_0000_FFFF, 2'd1, 16'h0000, 8'sd3, 8'h08));
    send_item(make_item(OP_PROBE, 64'h5555_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
    // Generation off the multiple-of-four grid: every hit refreshes.
    wait_drained();
    write_generation(8'hFF);
    send_item(make_item(OP_PROBE, 64'h0001_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_PROBE, 64'hABCD_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
  endtask

  task automatic test_clear_table();
    send_item(make_item(OP_CLEAR, 64'h0, 2'd0, 16'h0, 8'sd0, 8'h00));
    send_item(make_item(OP_PROBE, 64'h0001_0000_0000_FFFF, 2'd0, 16'h0, 8'sd0, 8'h00));
  endtask

  task automatic shuffle_hot_set();
    int i;
    for (i = 0; i < HOT_CLUSTERS; i++) hot_clusters[i] = CLUSTER_INDEX_BITS'($urandom);
    hot_clusters[0] = '0;
    hot_clusters[1] = '1;
    for (i = 0; i < HOT_TAGS; i++) hot_tags[i] = 16'($urandom);
  endtask

  task automatic test_output_backpressure();
    int i;
    wait_drained();
    write_generation({6'($urandom), 2'b00});
    shuffle_hot_set();
    tx_idle_on = 1'b0;
    rx_holdoff_cycles = 300;
    for (i = 0; i < 60; i++) send_item(random_item());
    // Hold off new items until every result is back.
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    int i;
    for (phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0: write_generation(8'd252);
        2: write_generation(8'($urandom));
        3: write_generation(8'd0);
        default: write_generation({6'($urandom), 2'b00});
      endcase
      shuffle_hot_set();
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      for (i = 0; i < 220; i++) begin
        if ((phase == 1 || phase == 3) && i == 110)
          send_item(make_item(OP_CLEAR, {$urandom, $urandom}, 2'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom)));
        else
          send_item(random_item());
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    int spin;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_hit_refresh_replace();
    test_clear_table();
    test_output_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    for (spin = 0; spin < END_LIMIT && pending_results.size() != 0; spin++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      fail_count += pending_results.size();
    end
    $display("Ran %0d probes (%0d hits), %0d writes, %0d clears, %0d unused-code items",
             probe_count, hit_count, write_count, clear_count, unused_count);
    $display("across %0d generation settings; %0d results checked, %0d failures",
             gen_settings, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
